FILE: sv/ppm_pkg.sv
// Shared constants, register codes and controller/datapath link types of the PPM decoder.
package ppm_pkg;

    localparam int CHANNEL_COUNT = 8;
    localparam int CHAN_IDX_W    = $clog2(CHANNEL_COUNT + 1);

    localparam int CNT_W        = 16;
    localparam int TPU_W        = 8;
    localparam int CHAN_W       = 3;
    localparam int RCV_W        = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CNT_W-1:0] TOP_RESET = 16'd30000;
    localparam logic [TPU_W-1:0] TPU_RESET = 8'd12;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOP_TICKS    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_US = 1'd1;

    // Restoring divider: one quotient bit per cycle
    localparam int DIV_STEPS = CNT_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    typedef struct packed {
        logic hit;        // counter matched top on this tick
        logic qual_edge;  // qualified edge on this tick
        logic full;       // frame already holds CHANNEL_COUNT channels
    } t_dp_status;

    typedef struct packed {
        logic clear_cnt;   // restart the tick counter
        logic toggle_pol;  // flip the awaited edge polarity
        logic clear_chan;  // restart the channel index
        logic emit;        // measure the current channel
    } t_ctrl_cmd;

endpackage

FILE: sv/ppm_if.sv
// Handshake channel interfaces: tick input, measurement output, configuration write.
interface ppm_in_if;
    logic valid;
    logic ready;
    logic pin_level;

    modport source (output valid, output pin_level, input ready);
    modport sink   (input valid, input pin_level, output ready);
endinterface

interface ppm_out_if import ppm_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] channel;
    logic [CNT_W-1:0]  width_us;
    logic [RCV_W-1:0]  received_count;

    modport source (output valid, output channel, output width_us, output received_count,
                    input ready);
    modport sink   (input valid, input channel, input width_us, input received_count,
                    output ready);
endinterface

interface ppm_cfg_if import ppm_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: sv/ppm_div.sv
// Restoring divider of a tick count by the ticks-per-microsecond divisor, one bit per cycle.
module ppm_div import ppm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_dividend,
    input  logic [TPU_W-1:0] i_divisor,
    input  logic             i_ack,
    output logic             o_busy,
    output logic             o_done,
    output logic [CNT_W-1:0] o_quotient
);

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_step;
    logic [TPU_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_q;
    logic [TPU_W-1:0]     r_div;

    logic [TPU_W:0] rem_sh;
    logic [TPU_W:0] diff;
    logic           ge;

    always_comb begin
        rem_sh = {r_rem, r_q[CNT_W-1]};
        diff   = rem_sh - {1'b0, r_div};
        ge     = (rem_sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else if (i_start) begin
            r_run  <= 1'b1;
            r_done <= 1'b0;
            r_step <= '0;
            r_rem  <= '0;
            r_q    <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_run) begin
            r_rem  <= ge ? diff[TPU_W-1:0] : rem_sh[TPU_W-1:0];
            r_q    <= {r_q[CNT_W-2:0], ge};
            r_step <= r_step + 1'b1;
            if (r_step == DIV_CNT_W'(DIV_STEPS - 1)) begin
                r_run  <= 1'b0;
                r_done <= 1'b1;
            end
        end else if (i_ack) begin
            r_done <= 1'b0;
        end
    end

    assign o_busy     = r_run | r_done;
    assign o_done     = r_done;
    assign o_quotient = r_q;

`ifndef SYNTH
    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_rem < r_div))
        else $error("divider remainder not below divisor");
`endif

endmodule

FILE: sv/ppm_ctrl.sv
// Decoder state machine: sync search, channel start, pulse end and next-channel edges.
module ppm_ctrl import ppm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_START = 3'd0,
        ST_NEXT  = 3'd1,
        ST_PAUSE = 3'd2,
        ST_SYNC  = 3'd3,
        ST_END   = 3'd4
    } t_state;

    t_state r_state;
    t_state n_state;
    t_state eff_state;

    always_comb begin
        eff_state = i_status.hit ? ST_SYNC : r_state;
        n_state   = eff_state;
        o_cmd     = '0;
        o_cmd.clear_cnt = i_status.hit;
        if (i_status.qual_edge) begin
            case (eff_state)
                ST_SYNC: begin
                    n_state          = ST_START;
                    o_cmd.clear_chan = 1'b1;
                    o_cmd.toggle_pol = 1'b1;
                end
                ST_START: begin
                    n_state          = ST_END;
                    o_cmd.clear_cnt  = 1'b1;
                    o_cmd.toggle_pol = 1'b1;
                end
                ST_END: begin
                    n_state          = ST_NEXT;
                    o_cmd.toggle_pol = 1'b1;
                end
                ST_NEXT: begin
                    n_state          = ST_END;
                    o_cmd.clear_cnt  = 1'b1;
                    o_cmd.toggle_pol = 1'b1;
                    o_cmd.emit       = !i_status.full;
                end
                default: begin
                    // Waiting for the pause: edges only restart the counter
                    n_state         = ST_PAUSE;
                    o_cmd.clear_cnt = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PAUSE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTH
    a_emit_to_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == ST_END))
        else $error("measurement not followed by pulse-end wait");

    a_sync_to_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.clear_chan |=> (r_state == ST_START))
        else $error("sync edge not followed by channel start wait");
`endif

endmodule

FILE: sv/ppm_dp.sv
// Datapath: tick counter, edge qualifier, channel index, config registers, divider, output word.
module ppm_dp import ppm_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ppm_in_if.sink         i_in,
    ppm_out_if.source      o_out,
    ppm_cfg_if.sink        i_cfg,
    input  t_ctrl_cmd      i_cmd,
    output t_dp_status     o_status
);

    logic [CNT_W-1:0]      r_top;
    logic [TPU_W-1:0]      r_tpu;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_wait_rise;
    logic                  r_last;
    logic [CHAN_IDX_W-1:0] r_chan_idx;
    logic [CHAN_W-1:0]     r_res_chan;
    logic [RCV_W-1:0]      r_res_rcv;
    logic                  r_out_valid;
    logic [CHAN_W-1:0]     r_out_chan;
    logic [CNT_W-1:0]      r_out_width;
    logic [RCV_W-1:0]      r_out_rcv;

    logic             tick;
    logic             hit;
    logic             eff_wr;
    logic             qual;
    logic [TPU_W-1:0] tpu_eff;
    logic [CNT_W-1:0] idx_ext;
    logic             div_busy;
    logic             div_done;
    logic             div_ack;
    logic             slot_free;
    logic [CNT_W-1:0] quot;

    assign i_in.ready  = !div_busy;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        tick    = i_in.valid & i_in.ready;
        hit     = tick & (r_cnt == r_top);
        eff_wr  = hit ? !i_in.pin_level : r_wait_rise;
        qual    = tick & (eff_wr ? (!r_last & i_in.pin_level) : (r_last & !i_in.pin_level));
        tpu_eff = (r_tpu == '0) ? TPU_W'(1) : r_tpu;
        idx_ext = CNT_W'(r_chan_idx);
        o_status.hit       = hit;
        o_status.qual_edge = qual;
        o_status.full      = (r_chan_idx >= CHAN_IDX_W'(CHANNEL_COUNT));
        slot_free = !r_out_valid | o_out.ready;
        div_ack   = div_done & slot_free;
    end

    ppm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.emit),
        .i_dividend (r_cnt),
        .i_divisor  (tpu_eff),
        .i_ack      (div_ack),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top       <= TOP_RESET;
            r_tpu       <= TPU_RESET;
            r_cnt       <= '0;
            r_wait_rise <= 1'b0;
            r_last      <= 1'b1;
            r_chan_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    REG_TOP_TICKS:    r_top <= i_cfg.data;
                    REG_TICKS_PER_US: r_tpu <= i_cfg.data[TPU_W-1:0];
                    default:          ;
                endcase
            end
            if (tick) begin
                r_last      <= i_in.pin_level;
                r_wait_rise <= eff_wr ^ i_cmd.toggle_pol;
                r_cnt       <= i_cmd.clear_cnt ? '0 : r_cnt + 1'b1;
            end
            if (i_cmd.clear_chan) begin
                r_chan_idx <= '0;
            end else if (i_cmd.emit) begin
                r_chan_idx <= r_chan_idx + 1'b1;
                r_res_chan <= idx_ext[CHAN_W-1:0];
                r_res_rcv  <= RCV_W'(idx_ext + CNT_W'(1));
            end
            if (div_ack) begin
                r_out_valid <= 1'b1;
                r_out_chan  <= r_res_chan;
                r_out_width <= quot;
                r_out_rcv   <= r_res_rcv;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.channel        = r_out_chan;
    assign o_out.width_us       = r_out_width;
    assign o_out.received_count = r_out_rcv;

`ifndef SYNTH
    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chan_idx <= CHAN_IDX_W'(CHANNEL_COUNT))
        else $error("channel index beyond frame size");

    a_emit_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |=> (r_chan_idx == $past(r_chan_idx) + 1'b1) && div_busy)
        else $error("measurement did not advance index or start divider");
`endif

endmodule

FILE: sv/ppm_pulse_train_decoder.sv
// A channel word is registered for output once the divider has run its 16 divide steps after the
// tick with its closing edge. Throughput: one tick per cycle; a tick that measures a channel holds
// off input while the shared bit-serial divider works, longer if the output word is not taken.
// Reset (synchronous, active low): wait for sync pause, counter 0, wait falling edge,
// last level high, channel index 0, top_ticks 30000, ticks_per_us 12, output empty.
module ppm_pulse_train_decoder import ppm_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ppm_in_if.sink    i_in,
    ppm_cfg_if.sink   i_cfg,
    ppm_out_if.source o_out
);

    // Control and status between the state machine and the datapath
    t_dp_status status;
    t_ctrl_cmd  cmd;

    // Decoder state machine: pause, sync, start, pulse end, next channel
    ppm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Counter, edge qualifier, channel index, divider and output word register
    ppm_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .o_out    (o_out),
        .i_cfg    (i_cfg),
        .i_cmd    (cmd),
        .o_status (status)
    );

endmodule
